// ===== hdl/assert_macros.svh =====
// assertion macros shared by the circle outline point generator
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define COP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define COP_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define COP_ASSERT(lbl, clk, rst_n, prop, msg)
`define COP_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/cop_pkg.sv =====
// shared types and constants for the circle outline point generator
// no dependencies; used by every module of the block
package cop_pkg;

	// parameter defaults
	localparam int MAX_RADIUS_DEF   = 255;
	localparam int OCTANT_DEPTH_DEF = 256;

	// octant point counter width (radius is 8 bits, so an octant has at most 183 points)
	localparam int CNT_W = 9;
	// width for comparing counts against the store depth (depth up to 4096)
	localparam int CMP_W = 13;
	// width of the fold arithmetic on list positions
	localparam int POS_W = 12;
	// width of the decision variable
	localparam int DEC_W = 12;

	localparam int RADIUS_W = 8;
	localparam int COORD_W  = 9;
	localparam int INDEX_W  = 11;
	localparam int ENTRY_W  = 16;

	// decision loop status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} gen_status_t;

	// top level sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BUILD = 4'b0010,
		ST_FOLD  = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

endpackage

// ===== hdl/cop_octant_gen.sv =====
// midpoint decision loop: one octant step per cycle on a shared update adder
// depends on cop_pkg and assert_macros.svh; writes points into cop_point_store
`include "assert_macros.svh"
module cop_octant_gen #(
	parameter int OCTANT_DEPTH = cop_pkg::OCTANT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cop_pkg::RADIUS_W-1:0]   radius_eff,
	output cop_pkg::gen_status_t           status,
	output logic [cop_pkg::CNT_W-1:0]      count,
	output logic                           wr_en,
	output logic [$clog2(OCTANT_DEPTH)-1:0] wr_addr,
	output logic [cop_pkg::ENTRY_W-1:0]    wr_data
);

	localparam int AW = $clog2(OCTANT_DEPTH);
	localparam logic [cop_pkg::CMP_W-1:0] DEPTH_V = cop_pkg::CMP_W'(OCTANT_DEPTH);

	logic                              busy_q;
	logic [cop_pkg::RADIUS_W:0]        x_q;
	logic [cop_pkg::RADIUS_W-1:0]      y_q;
	logic signed [cop_pkg::DEC_W-1:0]  d_q;
	logic [cop_pkg::CNT_W-1:0]         cnt_q;

	logic                              step_ok;
	logic                              d_neg;
	logic signed [cop_pkg::DEC_W-1:0]  diff;
	logic signed [cop_pkg::DEC_W-1:0]  addend;
	logic signed [cop_pkg::DEC_W-1:0]  d_next;
	logic [cop_pkg::RADIUS_W-1:0]      y_next;

	// loop continues while x <= y and the store has room
	assign step_ok = busy_q && (x_q <= {1'b0, y_q}) &&
		(cop_pkg::CMP_W'(cnt_q) < DEPTH_V);

	// shared decision update: d + 4x + 6 or d + 4(x - y) + 10
	always_comb begin
		d_neg  = d_q[cop_pkg::DEC_W-1];
		diff   = signed'(cop_pkg::DEC_W'(x_q)) - signed'(cop_pkg::DEC_W'(y_q));
		if (d_neg) begin
			addend = signed'(cop_pkg::DEC_W'({x_q, 2'b00})) + 12'sd6;
		end else begin
			addend = signed'({diff[cop_pkg::DEC_W-3:0], 2'b00}) + 12'sd10;
		end
		d_next = d_q + addend;
		y_next = d_neg ? y_q : y_q - 8'd1;
	end

	// store write: first point at start, one point per loop step
	always_comb begin
		wr_en   = start || step_ok;
		if (start) begin
			wr_addr = '0;
			wr_data = {radius_eff, 8'h00};
		end else begin
			wr_addr = AW'(cnt_q);
			wr_data = {y_next, x_q[cop_pkg::RADIUS_W-1:0]};
		end
	end

	// loop registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cop_pkg::CNT_W'(1);
		end else if (step_ok) begin
			cnt_q  <= cnt_q + 1'b1;
		end else if (busy_q) begin
			busy_q <= 1'b0;
		end
	end

	// working values of the loop
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= cop_pkg::RADIUS_W'(1) + 9'd0;
			y_q <= radius_eff;
			d_q <= 12'sd3 - signed'(cop_pkg::DEC_W'({radius_eff, 1'b0}));
		end else if (step_ok) begin
			x_q <= x_q + 1'b1;
			y_q <= y_next;
			d_q <= d_next;
		end
	end

	assign status.busy = busy_q;
	assign status.done = busy_q && !step_ok;
	assign count       = cnt_q;

	// checks
	`COP_ASSERT(a_cnt_in_store, clk, arst_n,
		busy_q |-> (cop_pkg::CMP_W'(cnt_q) <= DEPTH_V), "octant count beyond store depth")
	`COP_ASSERT(a_done_stops, clk, arst_n,
		(status.done && !start) |=> !busy_q, "loop still busy after done")

endmodule

// ===== hdl/cop_point_store.sv =====
// octant point memory: one write port, one registered read port
// depends on cop_pkg; filled by cop_octant_gen, read by the top level
module cop_point_store #(
	parameter int OCTANT_DEPTH = cop_pkg::OCTANT_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [$clog2(OCTANT_DEPTH)-1:0] wr_addr,
	input  logic [cop_pkg::ENTRY_W-1:0]     wr_data,
	input  logic                            rd_en,
	input  logic [$clog2(OCTANT_DEPTH)-1:0] rd_addr,
	output logic [cop_pkg::ENTRY_W-1:0]     rd_data
);

	logic [cop_pkg::ENTRY_W-1:0] mem_q [OCTANT_DEPTH];
	logic [cop_pkg::ENTRY_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/circle_outline_points.sv =====
// circle outline point generator, top level: sequencer, fold logic, output register
// depends on cop_pkg, cop_octant_gen, cop_point_store and assert_macros.svh
//
// Usage. cfg_we/cfg_wdata write the radius register (write only while idle).
// Each item on the s_ side (s_tdata[0] = restart) yields one point item on the
// m_ side: x, y, list position, and m_tlast on the final point of the outline.
// A restart item, the first item after reset, and any item after the final
// point rebuild the octant from the current radius and emit point 0.
// A next-point item is accepted only in idle. The acceptance cycle folds
// the list position and reads the store; the read state then forms the
// point and loads the output register, and s_tready returns at the same edge.
// A rebuilding item first runs the build state, where the decision loop writes
// one point per cycle into the store through one update adder, up to the octant
// point count (at most 183 for radius 255), then the fold and read states.
// A stalled receiver leaves the finished point in the output register; the
// next item is still accepted and waits with its point until the register
// frees. Reset clears the radius to 0, empties the list and the output.
`include "assert_macros.svh"
module circle_outline_points #(
	parameter int MAX_RADIUS   = cop_pkg::MAX_RADIUS_DEF,
	parameter int OCTANT_DEPTH = cop_pkg::OCTANT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: radius register
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [8:0] x_coord, [17:9] y_coord, [28:18] point_index, [31:29] zero
	output logic        m_tlast    // last_point
);

	localparam int AW = $clog2(OCTANT_DEPTH);
	localparam int PW = cop_pkg::POS_W;
	localparam int CW = cop_pkg::COORD_W;
	localparam logic [cop_pkg::CMP_W-1:0] DEPTH_V = cop_pkg::CMP_W'(OCTANT_DEPTH);
	localparam logic [PW-1:0] MAX_R_V = PW'(MAX_RADIUS);

	cop_pkg::state_t state_q;

	logic [cop_pkg::RADIUS_W-1:0] radius_q;
	logic                         list_valid_q;
	logic [cop_pkg::INDEX_W-1:0]  emit_index_q;
	logic                         swap_q;
	logic                         neg_x_q;
	logic                         neg_y_q;
	logic                         out_valid_q;
	logic [31:0]                  out_data_q;
	logic                         out_last_q;

	logic                         in_acc;
	logic                         rebuild;
	logic                         gen_start;
	logic [cop_pkg::RADIUS_W-1:0] radius_eff;
	cop_pkg::gen_status_t         gen_status;
	logic [cop_pkg::CNT_W-1:0]    oct_count;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [cop_pkg::ENTRY_W-1:0]  wr_data;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [cop_pkg::ENTRY_W-1:0]  rd_data;

	logic [PW-1:0] n_w, len1, len2, total;
	logic [PW-1:0] k0, k1, k2, k3;
	logic          f_neg_x, f_neg_y, f_swap;
	logic          out_load;
	logic [CW-1:0] px, py, ox, oy;
	logic          is_last;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// radius limited to the configured maximum
	assign radius_eff = (PW'(radius_q) > MAX_R_V) ? cop_pkg::RADIUS_W'(MAX_RADIUS) : radius_q;

	// list lengths of the octant and its mirror passes
	always_comb begin
		n_w   = PW'(oct_count);
		len1  = {n_w[PW-2:0], 1'b0} - 12'd1;
		len2  = {n_w[PW-3:0], 2'b00} - 12'd3;
		total = {n_w[PW-4:0], 3'b000} - 12'd7;
	end

	// fold the list position back into the octant
	always_comb begin
		k0      = PW'(emit_index_q);
		f_neg_x = (k0 >= len2);
		k1      = f_neg_x ? ({len2[PW-2:0], 1'b0} - 12'd2 - k0) : k0;
		f_neg_y = (k1 >= len1);
		k2      = f_neg_y ? ({len1[PW-2:0], 1'b0} - 12'd2 - k1) : k1;
		f_swap  = (k2 >= n_w);
		k3      = f_swap ? ({n_w[PW-2:0], 1'b0} - 12'd2 - k2) : k2;
		rd_addr = (cop_pkg::CMP_W'(k3) < DEPTH_V) ? AW'(k3) : '0;
	end

	// handshake and item decode
	assign s_tready  = (state_q == cop_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign rebuild   = s_tdata[0] || !list_valid_q || (PW'(emit_index_q) >= total);
	assign gen_start = in_acc && rebuild;
	assign rd_en     = (in_acc && !rebuild) || (state_q == cop_pkg::ST_FOLD);
	assign out_load  = (state_q == cop_pkg::ST_READ) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cop_pkg::ST_IDLE;
			list_valid_q <= 1'b0;
			emit_index_q <= '0;
		end else begin
			case (state_q)
				cop_pkg::ST_IDLE: begin
					if (gen_start) begin
						state_q      <= cop_pkg::ST_BUILD;
						list_valid_q <= 1'b1;
						emit_index_q <= '0;
					end else if (in_acc) begin
						state_q <= cop_pkg::ST_READ;
					end
				end
				cop_pkg::ST_BUILD: begin
					if (gen_status.done) begin
						state_q <= cop_pkg::ST_FOLD;
					end
				end
				cop_pkg::ST_FOLD: begin
					state_q <= cop_pkg::ST_READ;
				end
				cop_pkg::ST_READ: begin
					if (out_load) begin
						state_q      <= cop_pkg::ST_IDLE;
						emit_index_q <= emit_index_q + 1'b1;
					end
				end
				default: begin
					state_q <= cop_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// mirror flags travel with the store read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			swap_q  <= f_swap;
			neg_x_q <= f_neg_x;
			neg_y_q <= f_neg_y;
		end
	end

	// point from the stored octant entry
	always_comb begin
		px = {1'b0, rd_data[7:0]};
		py = {1'b0, rd_data[15:8]};
		if (swap_q) begin
			ox = py;
			oy = px;
		end else begin
			ox = px;
			oy = py;
		end
		if (neg_y_q) begin
			oy = CW'(0) - oy;
		end
		if (neg_x_q) begin
			ox = CW'(0) - ox;
		end
		is_last = (PW'(emit_index_q) + 12'd1 == total);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {3'b000, emit_index_q, oy, ox};
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	cop_octant_gen #(
		.OCTANT_DEPTH(OCTANT_DEPTH)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (gen_start),
		.radius_eff(radius_eff),
		.status    (gen_status),
		.count     (oct_count),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	cop_point_store #(
		.OCTANT_DEPTH(OCTANT_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// checks
	`COP_ASSERT(a_restart_builds, clk, arst_n,
		(in_acc && s_tdata[0]) |=> (state_q == cop_pkg::ST_BUILD), "restart did not rebuild")
	`COP_ASSERT(a_index_in_list, clk, arst_n,
		(list_valid_q && state_q != cop_pkg::ST_BUILD) |-> (PW'(emit_index_q) <= total),
		"emit position past end of list")
	`COP_NEVER(a_gen_idle_outside_build, clk, arst_n,
		gen_status.busy && state_q != cop_pkg::ST_BUILD, "decision loop busy outside build")

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for circle_outline_points: directed table, then random outline runs
// depends on cop_pkg and the circle_outline_points rtl; reads no files
module testbench;

	localparam bit ITEM_NEXT    = 1'b0;
	localparam bit ITEM_RESTART = 1'b1;
	localparam int RANDOM_ITEMS = 450;
	localparam int HOLD_CYCLES  = 60;
	localparam int IDLE_LIMIT   = 5000;
	localparam int LARGE_CAP    = 40;

	typedef struct packed {
		logic signed [cop_pkg::COORD_W-1:0] x;
		logic signed [cop_pkg::COORD_W-1:0] y;
		logic [cop_pkg::INDEX_W-1:0]        idx;
		logic                               last;
	} point_t;

	typedef struct {
		bit         set_r;
		logic [7:0] r;
		bit         restart;
		bit         typed;
		point_t     pt;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	circle_outline_points u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// shadow of the block: stored octant, list position, radius register
	logic [7:0]  oct_x [cop_pkg::OCTANT_DEPTH_DEF];
	logic [7:0]  oct_y [cop_pkg::OCTANT_DEPTH_DEF];
	int unsigned oct_n;
	int unsigned next_pos;
	bit          have_list;
	logic [7:0]  radius_q;

	point_t pending_points[$];
	bit     quiet;
	bit     hold_req;
	bit     last_pred;
	int     failures;
	int     points_checked;
	int     outlines_seen;
	int     restarts_sent;
	int     radius_writes;
	int     idle_cycles;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// midpoint decision loop over one octant, from (0,r)
	function automatic void rebuild_octant();
		int r, cx, cy, dec;
		r = (radius_q > cop_pkg::MAX_RADIUS_DEF) ? cop_pkg::MAX_RADIUS_DEF : radius_q;
		oct_x[0] = 8'd0;
		oct_y[0] = r[7:0];
		oct_n = 1;
		cx = 1;
		cy = r;
		dec = 3 - 2 * r;
		if (r > 0) begin
			while (cx <= cy && oct_n < cop_pkg::OCTANT_DEPTH_DEF) begin
				if (dec < 0) begin
					dec = dec + 4 * cx + 6;
				end else begin
					dec = dec + 4 * (cx - cy) + 10;
					cy = cy - 1;
				end
				oct_x[oct_n] = cx[7:0];
				oct_y[oct_n] = cy[7:0];
				oct_n++;
				cx++;
			end
		end
		next_pos = 0;
		have_list = 1'b1;
	endfunction

	// next outline point: fold the list position back onto the octant
	function automatic point_t next_point(bit restart);
		int unsigned n, len1, len2, whole, k;
		bit fx, fy, sw;
		int px, py, t;
		point_t p;
		if (restart || !have_list || next_pos >= 8 * oct_n - 7)
			rebuild_octant();
		n = oct_n;
		len1 = 2 * n - 1;
		len2 = 4 * n - 3;
		whole = 8 * n - 7;
		k = next_pos;
		fx = 1'b0;
		fy = 1'b0;
		sw = 1'b0;
		if (k >= len2) begin k = 2 * len2 - 2 - k; fx = 1'b1; end
		if (k >= len1) begin k = 2 * len1 - 2 - k; fy = 1'b1; end
		if (k >= n) begin k = 2 * n - 2 - k; sw = 1'b1; end
		if (k >= cop_pkg::OCTANT_DEPTH_DEF)
			k = 0;
		px = oct_x[k];
		py = oct_y[k];
		if (sw) begin t = px; px = py; py = t; end
		if (fy) py = -py;
		if (fx) px = -px;
		p.x = px[cop_pkg::COORD_W-1:0];
		p.y = py[cop_pkg::COORD_W-1:0];
		p.idx = next_pos[cop_pkg::INDEX_W-1:0];
		p.last = (next_pos + 1 == whole);
		next_pos++;
		return p;
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			failures++;
		end
	endfunction

	// offer one item, wait for acceptance, then record the point it must give
	task automatic offer_item(input bit restart, input bit typed, input point_t typed_pt);
		int gap;
		point_t p;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = next_point(restart);
		pending_points.push_back(typed ? typed_pt : p);
		last_pred = p.last;
		if (restart) restarts_sent++;
	endtask

	// stop offering and let every outstanding point come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_radius(input logic [7:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_q = value;
		radius_writes++;
	endtask

	// directed table: reset behaviour, extremes, radius change mid-list, wrap after last point
	step_row_t steps [25] = '{
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b1, '{9'sd0, 9'sd0,   11'd0, 1'b1}},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b1, '{9'sd0, 9'sd0,   11'd0, 1'b1}},
		'{1'b0, 8'd0,   ITEM_RESTART, 1'b1, '{9'sd0, 9'sd0,   11'd0, 1'b1}},
		'{1'b1, 8'd255, ITEM_RESTART, 1'b1, '{9'sd0, 9'sd255, 11'd0, 1'b0}},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b1, 8'd1,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_RESTART, 1'b1, '{9'sd0, 9'sd1,   11'd0, 1'b0}},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b1, '{9'sd0, 9'sd1,   11'd0, 1'b0}},
		'{1'b1, 8'd2,   ITEM_RESTART, 1'b1, '{9'sd0, 9'sd2,   11'd0, 1'b0}},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b0, 8'd0,   ITEM_NEXT,    1'b0, '0},
		'{1'b1, 8'd0,   ITEM_NEXT,    1'b0, '0}
	};

	// result side: random stalls, one long hold-off on request, field checks
	initial begin : take_points
		int stall;
		point_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected item, expected none, got x=%0d y=%0d index=%0d last=%0b",
					$time, $signed(m_tdata[8:0]), $signed(m_tdata[17:9]),
					m_tdata[28:18], m_tlast);
				failures++;
			end else begin
				want = pending_points.pop_front();
				check_field("x_coord", want.x, $signed(m_tdata[8:0]));
				check_field("y_coord", want.y, $signed(m_tdata[17:9]));
				check_field("point_index", want.idx, m_tdata[28:18]);
				check_field("last_point", want.last, m_tlast);
				points_checked++;
			end
			if (m_tlast) outlines_seen++;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("circle_outline_points: mismatch");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : drive_items
		int sent, phase, sel, mode, cnt, extra, cap;
		logic [7:0] r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		quiet = 1'b0;
		hold_req = 1'b0;
		failures = 0;
		points_checked = 0;
		outlines_seen = 0;
		restarts_sent = 0;
		radius_writes = 0;
		idle_cycles = 0;
		radius_q = 8'd0;
		have_list = 1'b0;
		oct_n = 0;
		next_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (steps[i]) begin
			if (steps[i].set_r) write_radius(steps[i].r);
			offer_item(steps[i].restart, steps[i].typed, steps[i].pt);
		end

		// random outline runs: mostly complete outlines of small circles
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) r = 8'd0;
			else if (sel == 1) r = 8'd255;
			else if (sel <= 4) r = 8'($urandom_range(21, 80));
			else r = 8'($urandom_range(1, 20));
			mode = $urandom_range(0, 9);
			quiet = ($urandom_range(0, 3) == 0);
			if (phase == 1) begin
				// long receiver hold-off while items keep coming
				r = 8'($urandom_range(8, 20));
				mode = 2;
				quiet = 1'b1;
				hold_req = 1'b1;
			end
			if (phase == 1 || $urandom_range(0, 3) != 0)
				write_radius(r);
			else
				wait_idle();
			cap = (radius_q > 20) ? LARGE_CAP : 2048;
			if (mode == 0) begin
				// carry on with the list built earlier
				cnt = $urandom_range(1, 12);
				repeat (cnt) begin
					offer_item(ITEM_NEXT, 1'b0, '0);
					sent++;
				end
			end else if (mode == 1) begin
				// broken sequence: restarts scattered among next requests
				cnt = $urandom_range(1, 8);
				repeat (cnt) begin
					offer_item(1'($urandom_range(0, 1)), 1'b0, '0);
					sent++;
				end
			end else begin
				offer_item(ITEM_RESTART, 1'b0, '0);
				sent++;
				cnt = 1;
				while (!last_pred && cnt < cap) begin
					offer_item(ITEM_NEXT, 1'b0, '0);
					sent++;
					cnt++;
				end
				// extra requests, which wrap to a fresh outline when they come past the final point
				extra = $urandom_range(0, 2);
				repeat (extra) begin
					offer_item(ITEM_NEXT, 1'b0, '0);
					sent++;
				end
			end
			phase++;
		end

		quiet = 1'b0;
		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d outline points, %0d full outlines, %0d restarts, %0d radius writes",
			points_checked, outlines_seen, restarts_sent, radius_writes);
		if (failures == 0 && pending_points.size() == 0) begin
			$display("circle_outline_points: match");
		end else begin
			$display("circle_outline_points: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cop_pkg.sv
hdl/cop_octant_gen.sv
hdl/cop_point_store.sv
hdl/circle_outline_points.sv
verif/testbench.sv
